// File: rtl/tcc_pkg.sv
// Shared types and constants of the text command calculator.
package tcc_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CHAR_W     = 8;
    localparam int RESULT_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int DIV_CNT_W  = $clog2(VALUE_BITS);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_MUL,
        OP_SUB,
        OP_DIV
    } op_t;

    typedef enum logic [2:0] {
        SEL_ADD,
        SEL_SUB,
        SEL_PROD,
        SEL_QUOT,
        SEL_UNKNOWN,
        SEL_DIVZERO
    } res_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic     keep_letter;
        logic     acc_first;
        logic     acc_second;
        logic     clear;
        logic     mul_capture;
        logic     div_start;
        logic     div_step;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } tcc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_space;
        op_t  op;
        logic divisor_zero;
    } tcc_sts_t;

endpackage

// File: rtl/tcc_datapath.sv
// Datapath: command letters, operand accumulators, multiplier, divider, result registers.
module tcc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tcc_pkg::CHAR_W-1:0]      character,
    input  tcc_pkg::tcc_cmd_t               cmd,
    output tcc_pkg::tcc_sts_t               sts,
    output logic [tcc_pkg::RESULT_W-1:0]    out_result,
    output logic [tcc_pkg::STATUS_W-1:0]    out_status
);

    localparam int VB = tcc_pkg::VALUE_BITS;
    localparam logic [tcc_pkg::CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [tcc_pkg::CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [23:0] NAME_ADD = "add";
    localparam logic [23:0] NAME_MUL = "mul";
    localparam logic [23:0] NAME_SUB = "sub";
    localparam logic [23:0] NAME_DIV = "div";

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [VB-1:0] accumulate(input logic [VB-1:0] v,
                                                input logic [7:0] c);
        accumulate = (v << 3) + (v << 1) + VB'(c) - VB'(CH_ZERO);
    endfunction

    function automatic logic [VB-1:0] magnitude(input logic [VB-1:0] v);
        magnitude = v[VB-1] ? (~v + VB'(1)) : v;
    endfunction

    logic [7:0]    letters_reg [4];
    logic [2:0]    length_reg;
    logic [VB-1:0] first_reg;
    logic [VB-1:0] second_reg;
    logic [VB-1:0] prod_reg;
    logic [VB-1:0] rem_reg;
    logic [VB-1:0] quo_reg;
    logic [VB-1:0] dvs_reg;
    logic          neg_reg;
    logic [VB-1:0] res_reg;
    logic [tcc_pkg::STATUS_W-1:0] res_status_reg;
    logic [tcc_pkg::RESULT_W-1:0] out_result_reg;
    logic [tcc_pkg::STATUS_W-1:0] out_status_reg;

    logic [23:0]   word;
    logic [VB:0]   rem_shift;
    logic [VB:0]   trial;

    assign word = {fold(letters_reg[0]), fold(letters_reg[1]), fold(letters_reg[2])};

    always_comb begin
        sts.is_space     = (character == CH_SPACE);
        sts.divisor_zero = (second_reg == '0);
        sts.op           = tcc_pkg::OP_NONE;
        if (length_reg == 3'd3) begin
            if (word == NAME_ADD) begin
                sts.op = tcc_pkg::OP_ADD;
            end else if (word == NAME_MUL) begin
                sts.op = tcc_pkg::OP_MUL;
            end else if (word == NAME_SUB) begin
                sts.op = tcc_pkg::OP_SUB;
            end else if (word == NAME_DIV) begin
                sts.op = tcc_pkg::OP_DIV;
            end
        end
    end

    // restoring divider, one quotient bit per step; remainder stays below the divisor
    assign rem_shift = {rem_reg, quo_reg[VB-1]};
    assign trial     = rem_shift - {1'b0, dvs_reg};

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < 4; i++) begin
                letters_reg[i] <= '0;
            end
            length_reg <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end else begin
            if (cmd.keep_letter && length_reg < 3'd4) begin
                letters_reg[length_reg[1:0]] <= character;
                length_reg                   <= length_reg + 3'd1;
            end
            if (cmd.acc_first) begin
                first_reg <= accumulate(first_reg, character);
            end
            if (cmd.acc_second) begin
                second_reg <= accumulate(second_reg, character);
            end
        end
    end

    // arithmetic and result payload
    always_ff @(posedge aclk) begin
        if (cmd.mul_capture) begin
            prod_reg <= first_reg * second_reg;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= magnitude(first_reg);
            dvs_reg <= magnitude(second_reg);
            neg_reg <= first_reg[VB-1] ^ second_reg[VB-1];
        end else if (cmd.div_step) begin
            if (!trial[VB]) begin
                rem_reg <= trial[VB-1:0];
                quo_reg <= {quo_reg[VB-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[VB-1:0];
                quo_reg <= {quo_reg[VB-2:0], 1'b0};
            end
        end
        if (cmd.res_load) begin
            case (cmd.res_sel)
                tcc_pkg::SEL_ADD: begin
                    res_reg        <= first_reg + second_reg;
                    res_status_reg <= tcc_pkg::ST_OK;
                end
                tcc_pkg::SEL_SUB: begin
                    res_reg        <= first_reg - second_reg;
                    res_status_reg <= tcc_pkg::ST_OK;
                end
                tcc_pkg::SEL_PROD: begin
                    res_reg        <= prod_reg;
                    res_status_reg <= tcc_pkg::ST_OK;
                end
                tcc_pkg::SEL_QUOT: begin
                    res_reg        <= neg_reg ? (~quo_reg + VB'(1)) : quo_reg;
                    res_status_reg <= tcc_pkg::ST_OK;
                end
                tcc_pkg::SEL_DIVZERO: begin
                    res_reg        <= '0;
                    res_status_reg <= tcc_pkg::ST_DIVZERO;
                end
                default: begin
                    res_reg        <= '0;
                    res_status_reg <= tcc_pkg::ST_UNKNOWN;
                end
            endcase
        end
        if (cmd.out_load) begin
            out_result_reg <= tcc_pkg::RESULT_W'(res_reg);
            out_status_reg <= res_status_reg;
        end
    end

    assign out_result = out_result_reg;
    assign out_status = out_status_reg;

endmodule

// File: rtl/tcc_controller.sv
// Controller: line parsing phases and evaluation sequencing.
module tcc_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  tcc_pkg::tcc_sts_t   sts,
    output tcc_pkg::tcc_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_PARSE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_CMD,
        PH_GAP1,
        PH_OP1,
        PH_GAP2,
        PH_OP2,
        PH_REST
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [tcc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic accept;
    logic slot_free;

    assign s_tready  = (state_reg == S_PARSE);
    assign m_tvalid  = m_tvalid_reg;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.res_sel   = tcc_pkg::SEL_UNKNOWN;

        case (state_reg)
            S_PARSE: begin
                if (accept) begin
                    case (phase_reg)
                        PH_LEAD: begin
                            if (!sts.is_space) begin
                                phase_next      = PH_CMD;
                                cmd.keep_letter = 1'b1;
                            end
                        end
                        PH_CMD: begin
                            if (sts.is_space) begin
                                phase_next = PH_GAP1;
                            end else begin
                                cmd.keep_letter = 1'b1;
                            end
                        end
                        PH_GAP1: begin
                            if (!sts.is_space) begin
                                phase_next    = PH_OP1;
                                cmd.acc_first = 1'b1;
                            end
                        end
                        PH_OP1: begin
                            if (sts.is_space) begin
                                phase_next = PH_GAP2;
                            end else begin
                                cmd.acc_first = 1'b1;
                            end
                        end
                        PH_GAP2: begin
                            if (!sts.is_space) begin
                                phase_next     = PH_OP2;
                                cmd.acc_second = 1'b1;
                            end
                        end
                        PH_OP2: begin
                            if (sts.is_space) begin
                                phase_next = PH_REST;
                            end else begin
                                cmd.acc_second = 1'b1;
                            end
                        end
                        default: begin
                            phase_next = PH_REST;
                        end
                    endcase
                    if (s_tlast) begin
                        phase_next = PH_LEAD;
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                case (sts.op)
                    tcc_pkg::OP_ADD: begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = tcc_pkg::SEL_ADD;
                        state_next   = S_DONE;
                    end
                    tcc_pkg::OP_SUB: begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = tcc_pkg::SEL_SUB;
                        state_next   = S_DONE;
                    end
                    tcc_pkg::OP_MUL: begin
                        cmd.mul_capture = 1'b1;
                        state_next      = S_MUL;
                    end
                    tcc_pkg::OP_DIV: begin
                        if (sts.divisor_zero) begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = tcc_pkg::SEL_DIVZERO;
                            state_next   = S_DONE;
                        end else begin
                            cmd.div_start = 1'b1;
                            cnt_next      = tcc_pkg::DIV_CNT_W'(tcc_pkg::VALUE_BITS - 1);
                            state_next    = S_DIV;
                        end
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = tcc_pkg::SEL_UNKNOWN;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_MUL: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = tcc_pkg::SEL_PROD;
                state_next   = S_DONE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - tcc_pkg::DIV_CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = S_DIVFIN;
                end
            end
            S_DIVFIN: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = tcc_pkg::SEL_QUOT;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.clear     = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_PARSE;
                end
            end
            default: begin
                state_next = S_PARSE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_PARSE;
            phase_reg    <= PH_LEAD;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: rtl/text_command_calculator.sv
// Top level of the text command calculator: "cmd a b" line in, one result per line out.
// Throughput: one character per cycle while a line is parsed; s_tready drops after the last one.
// After the last character, S_EXEC loads the result of add, sub, unknown command and divide by
// zero, S_MUL that of mul, S_DIVFIN that of div after the one-bit-per-cycle restoring divider
// in S_DIV; S_DONE raises m_tvalid. A waiting result does not block parsing of the next line.
// Reset: aresetn synchronous, active low; clears the phase, command letters, operands, m_tvalid.
module text_command_calculator (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // last character of the line
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result (signed)
    output logic [1:0]  m_tuser    // [1:0] status: ok, unknown command, divide by zero
);

    tcc_pkg::tcc_cmd_t cmd;
    tcc_pkg::tcc_sts_t sts;

    // FSM: phase tracking on each transaction, then the evaluation sequence
    tcc_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // letters, operands, multiplier, divider and the output register
    tcc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .character  (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_result (m_tdata),
        .out_status (m_tuser)
    );

    // the block takes no character while a line is being evaluated
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted during evaluation");

    // status code 3 is never produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("invalid status code");

    // error results carry a zero value
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == tcc_pkg::ST_UNKNOWN || m_tuser == tcc_pkg::ST_DIVZERO))
        |-> (m_tdata == '0))
        else $error("non-zero result with error status");

endmodule
